// File: hw/rtl/hsv_pkg.sv
// ============================================================================
// hsv_pkg: shared types and constants for the harmonic sine voice
// Holds register indexes, mode codes, fixed-point constants, the note
// frequency table and the elaboration-time quarter-sine generator.
// ============================================================================
package hsv_pkg;

  // Signed 16-bit audio sample.
  typedef logic signed [15:0] sample_t;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;

  // One request to the shared multiplier.
  typedef struct packed {
    logic             en;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] DECAY_RESET  = 16'd65503;
  localparam logic [15:0] CUTOFF_RESET = 16'd7;
  localparam logic [15:0] GAIN_RESET   = 16'd19661;

  // Input item modes.
  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

  // Envelope at note on.
  localparam logic [15:0] ENV_FULL = 16'hFFFF;

  // Rounding bias for the divide by 127 * 2^34 (half the divisor).
  localparam int ACC_W = 58;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(127) << 33;

  // ceil(2^32 / 127): exact quotient by 127 for every value below 2^25.
  localparam logic [MUL_W-1:0] RECIP_127 = 26'd33818641;

  // Upper bound on the voice magnitude checked by the a_voice_range assertion.
  localparam logic [19:0] VOICE_MAX = 20'd57343;

  // MIDI notes and the frequencies of notes 0 to 11 in Hz * 2^24.
  localparam int NOTE_CNT = 128;
  localparam logic [31:0] BASE_FREQ_Q24 [12] = '{
    32'd137167144, 32'd145323527, 32'd153964914, 32'd163120144,
    32'd172819773, 32'd183096171, 32'd193983636, 32'd205518503,
    32'd217739269, 32'd230686720, 32'd244404066, 32'd258937088
  };

  // Quarter-sine generator constants.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [6] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
  };

  // One quarter-wave entry: round(32767 * sin(j * pi / 2 / 2^(tbits-2))),
  // with the sine taken from a Q30 Taylor series. Used with constant
  // arguments only, so it folds to a constant.
  function automatic logic [14:0] quarter_entry(input int unsigned j,
                                                 input int unsigned tbits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    x    = (HALF_PI_Q30 * 64'(j)) >> (tbits - 2);
    sum  = signed'(x);
    term = x;
    for (int k = 1; k <= 6; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / TAYLOR_DIV[k-1];
      if ((k & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = ((unsigned'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

// File: hw/rtl/hsv_sine_rom.sv
// ============================================================================
// hsv_sine_rom: quarter-wave sine lookup
// Folds a 32-bit phase onto a quarter-wave table and returns the signed
// sine value in the cycle after the phase is presented.
// ============================================================================
module hsv_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic             clk,
  input  logic [31:0]      phase,
  output hsv_pkg::sample_t sine
);
  import hsv_pkg::*;

  localparam int QLEN = 1 << (SINE_TABLE_BITS - 2);
  localparam int AW   = SINE_TABLE_BITS - 1;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS-3:0] j;
  logic [AW-1:0]              addr;
  logic [14:0]                qtab [QLEN+1];
  logic [14:0]                mag_r;
  logic                       neg_r;

  // Constant quarter-wave table, built at elaboration.
  for (genvar g = 0; g <= QLEN; g++) begin : g_tab
    assign qtab[g] = quarter_entry(g, SINE_TABLE_BITS);
  end

  // Quadrant fold: odd quadrants run the table backwards.
  assign idx  = phase[31 -: SINE_TABLE_BITS];
  assign j    = idx[SINE_TABLE_BITS-3:0];
  assign addr = idx[SINE_TABLE_BITS-2] ? (AW'(QLEN) - AW'(j)) : AW'(j);

  // Registered table read; the lower half-wave is negated afterwards.
  always_ff @(posedge clk) begin
    mag_r <= qtab[addr];
    neg_r <= idx[SINE_TABLE_BITS-1];
  end

  assign sine = neg_r ? -sample_t'(mag_r) : sample_t'(mag_r);

endmodule

// File: hw/rtl/hsv_mul.sv
// ============================================================================
// hsv_mul: shared multiplier
// Unsigned multiplier with a registered product, reused for every product
// of the voice computation. The product holds when no request is made.
// ============================================================================
module hsv_mul (
  input  logic                           clk,
  input  hsv_pkg::mul_req_t              req,
  output logic [hsv_pkg::PROD_W-1:0]     prod
);
  import hsv_pkg::*;

  logic [PROD_W-1:0] prod_r;

  // One product per request, available on the next cycle.
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= PROD_W'(req.a) * PROD_W'(req.b);
    end
  end

  assign prod = prod_r;

endmodule

// File: hw/rtl/harmonic_sine_voice.sv
// ============================================================================
// harmonic_sine_voice: mono three-harmonic sine voice with decaying envelope
// Note events set up the voice; each tick beat returns mix_in plus the
// voice sample, saturated to 16 bits.
// ============================================================================
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------
//  in_     | input     | mode, note, note_velocity, mix_in
//  out_    | output    | sample_out (one beat per tick, none for notes)
//  cfg_    | input     | decay_factor, cutoff_level, output_gain writes
//
//  A note beat or a mode-three beat is taken while idle. A silent tick goes
//  to S_DONE; a sounding tick steps through S_SIN0 to S_UPD, walking the
//  sine table three times and the shared multiplier through six products.
//  in_ready is high only while the sequencer is idle.
//  A finished sample waits in the output register; a stalled out_ready holds
//  the next tick in its last step until the register is free.
//  Reset is synchronous.
//
module harmonic_sine_voice #(
  parameter int SAMPLE_RATE_HZ  = 48000,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic [6:0]                      in_note,
  input  logic [6:0]                      in_note_velocity,
  input  hsv_pkg::sample_t                in_mix_in,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output hsv_pkg::sample_t                out_sample_out,
  // Configuration port
  input  logic                            cfg_wr_en,
  input  logic [hsv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_wdata
);
  import hsv_pkg::*;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SIN0 = 4'd1;
  localparam logic [3:0] S_SIN1 = 4'd2;
  localparam logic [3:0] S_SIN2 = 4'd3;
  localparam logic [3:0] S_SIN3 = 4'd4;
  localparam logic [3:0] S_MAG  = 4'd5;
  localparam logic [3:0] S_PLO  = 4'd6;
  localparam logic [3:0] S_PHI  = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_RCP  = 4'd9;
  localparam logic [3:0] S_DEC  = 4'd10;
  localparam logic [3:0] S_UPD  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]         state_r;
  logic [31:0]        phase_acc_r;
  logic [31:0]        phase_step_r;
  logic [15:0]        env_r;
  logic [6:0]         vel_r;
  logic               playing_r;
  logic [15:0]        decay_r;
  logic [15:0]        cutoff_r;
  logic [15:0]        gain_r;
  sample_t            mix_r;
  logic signed [18:0] h_r;
  logic               neg_r;
  logic [22:0]        g_r;
  logic [16:0]        a_hi_r;
  logic [ACC_W-1:0]   acc_r;
  logic [19:0]        r_r;
  logic               out_valid_r;
  sample_t            out_sample_r;

  logic [31:0]        step_tab [NOTE_CNT];
  logic [31:0]        phase2;
  logic [31:0]        rom_phase;
  sample_t            sine;
  mul_req_t           mul_req;
  logic [PROD_W-1:0]  prod;
  logic [17:0]        mag;
  logic signed [20:0] total;
  sample_t            sat;
  logic               in_fire;
  logic               out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Phase step for each note, rounded at elaboration.
  for (genvar n = 0; n < NOTE_CNT; n++) begin : g_step
    localparam logic [63:0] NUM  = 64'(BASE_FREQ_Q24[n % 12]) << (n / 12 + 8);
    localparam logic [63:0] STEP =
      (NUM + 64'(SAMPLE_RATE_HZ / 2)) / 64'(SAMPLE_RATE_HZ);
    assign step_tab[n] = STEP[31:0];
  end

  // Sine table address: fundamental, second and third harmonic phase.
  assign phase2 = phase_acc_r << 1;
  always_comb begin
    case (state_r)
      S_SIN1:  rom_phase = phase2;
      S_SIN2:  rom_phase = phase2 + phase_acc_r;
      default: rom_phase = phase_acc_r;
    endcase
  end

  hsv_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk   (clk),
    .phase (rom_phase),
    .sine  (sine)
  );

  // Magnitude of the harmonic sum.
  assign mag = h_r[18] ? 18'(-h_r) : 18'(h_r);

  // Multiplier operands for each sequencer step.
  always_comb begin
    mul_req = '0;
    case (state_r)
      S_SIN0: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(vel_r);
        mul_req.b  = MUL_W'(gain_r);
      end
      S_MAG: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(mag);
        mul_req.b  = MUL_W'(env_r);
      end
      S_PLO: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(prod[16:0]);
        mul_req.b  = MUL_W'(g_r);
      end
      S_PHI: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(a_hi_r);
        mul_req.b  = MUL_W'(g_r);
      end
      S_RCP: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(acc_r[ACC_W-1:34]);
        mul_req.b  = RECIP_127;
      end
      S_DEC: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(env_r);
        mul_req.b  = MUL_W'(decay_r);
      end
      default: mul_req = '0;
    endcase
  end

  hsv_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // Final sum and saturation.
  assign total = 21'(mix_r) + (neg_r ? -21'(r_r) : 21'(r_r));
  always_comb begin
    if (total > 21'sd32767) begin
      sat = 16'sh7FFF;
    end else if (total < -21'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = total[15:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= DECAY_RESET;
      cutoff_r <= CUTOFF_RESET;
      gain_r   <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DECAY:  decay_r  <= cfg_wdata;
        CFG_CUTOFF: cutoff_r <= cfg_wdata;
        CFG_GAIN:   gain_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and voice state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_acc_r  <= '0;
      phase_step_r <= '0;
      env_r        <= '0;
      vel_r        <= '0;
      playing_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mix_r <= in_mix_in;
            unique case (in_mode)
              MODE_NOTE_ON: begin
                if (in_note_velocity != 7'd0) begin
                  phase_step_r <= step_tab[in_note];
                  vel_r        <= in_note_velocity;
                  env_r        <= ENV_FULL;
                  phase_acc_r  <= '0;
                  playing_r    <= 1'b1;
                end else begin
                  playing_r <= 1'b0;
                end
              end
              MODE_NOTE_OFF: playing_r <= 1'b0;
              MODE_TICK: begin
                if (playing_r && (env_r > cutoff_r)) begin
                  state_r <= S_SIN0;
                end else begin
                  r_r     <= '0;
                  neg_r   <= 1'b0;
                  state_r <= S_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_SIN0: state_r <= S_SIN1;
        S_SIN1: begin
          h_r     <= 19'(sine) <<< 2;
          g_r     <= prod[22:0];
          state_r <= S_SIN2;
        end
        S_SIN2: begin
          h_r     <= h_r + (19'(sine) <<< 1);
          state_r <= S_SIN3;
        end
        S_SIN3: begin
          h_r     <= h_r + 19'(sine);
          state_r <= S_MAG;
        end
        S_MAG: begin
          neg_r   <= h_r[18];
          state_r <= S_PLO;
        end
        S_PLO: begin
          a_hi_r  <= prod[33:17];
          acc_r   <= ROUND_BIAS;
          state_r <= S_PHI;
        end
        S_PHI: begin
          acc_r   <= acc_r + ACC_W'(prod);
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + (ACC_W'(prod) << 17);
          state_r <= S_RCP;
        end
        S_RCP: state_r <= S_DEC;
        S_DEC: begin
          r_r     <= prod[51:32];
          state_r <= S_UPD;
        end
        S_UPD: begin
          env_r       <= prod[31:16];
          phase_acc_r <= phase_acc_r + phase_step_r;
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_valid_r  <= 1'b1;
      out_sample_r <= sat;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // The envelope never grows during a tick.
  a_env_falls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> (env_r <= $past(env_r)))
    else $error("envelope rose during a tick");

  // The phase moves only on a sounding tick or a note event.
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_UPD) && !in_fire) |=> $stable(phase_acc_r))
    else $error("phase changed outside a tick update");

  // Only a playing voice enters the arithmetic.
  a_play_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIN0) |-> playing_r)
    else $error("silent voice entered the arithmetic");

  // The scaled voice value stays at or below VOICE_MAX.
  a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (r_r <= VOICE_MAX))
    else $error("voice value out of range");

endmodule
